[hw/rtl/assert_macros.svh]
// ----------------------------------------------------------------------------
// assert_macros
// Assertion macros shared by the queue RTL.
// Define NO_ASSERTIONS to compile all checks out.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define DQ_ASSERT_CLK(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define DQ_ASSERT(label, prop, msg) \
   `DQ_ASSERT_CLK(label, clock, reset, prop, msg)
`else
`define DQ_ASSERT_CLK(label, clk, rst, prop, msg)
`define DQ_ASSERT(label, prop, msg)
`endif
`endif

[hw/rtl/dq_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dq_pkg
// Shared sizes, codes and controller/datapath interface types of the queue.
// ----------------------------------------------------------------------------
package dq_pkg;

   localparam int DEPTH      = 64;
   localparam int DATA_WIDTH = 32;
   localparam int SLOT_W     = $clog2(DEPTH);
   localparam int COUNT_W    = 7;
   localparam int INDEX_W    = 7;
   localparam int OPCODE_W   = 3;
   localparam int STATUS_W   = 2;

   typedef enum logic [OPCODE_W-1:0] {
      OP_PUSH_BACK  = 3'd0,
      OP_PUSH_FRONT = 3'd1,
      OP_POP_BACK   = 3'd2,
      OP_POP_FRONT  = 3'd3,
      OP_READ       = 3'd4,
      OP_WRITE      = 3'd5,
      OP_INSERT     = 3'd6,
      OP_ERASE      = 3'd7
   } dq_op_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK    = 2'd0,
      ST_FULL  = 2'd1,
      ST_EMPTY = 2'd2,
      ST_RANGE = 2'd3
   } dq_status_type;

   // controller -> datapath
   typedef struct packed {
      logic load_req;   // capture the accepted request
      logic wr_target;  // write request data at the target slot
      logic rd_target;  // read the target slot
      logic ptr_load;   // start a shift walk
      logic shift_rd;   // read the neighbor of the walk pointer
      logic shift_wr;   // write it at the walk pointer and step
      logic finish;     // commit head/count and load the response
   } dq_cmd_type;

   // datapath -> controller
   typedef struct packed {
      dq_op_type op;
      logic      err;        // request fails its full/empty/range check
      logic      shift_more; // walk has another element to move
      logic      out_free;   // response register can take a new response
   } dq_stat_type;

endpackage

[hw/rtl/dq_datapath.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dq_datapath
// Ring storage, head/count registers, shift walk pointer and response register.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"
module dq_datapath
   import dq_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  dq_cmd_type            cmd,
   output dq_stat_type           stat,
   input  logic [OPCODE_W-1:0]   req_opcode,
   input  logic [INDEX_W-1:0]    req_index,
   input  logic [DATA_WIDTH-1:0] req_data_in,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [DATA_WIDTH-1:0] rsp_data_out,
   output logic [STATUS_W-1:0]   rsp_status,
   output logic [COUNT_W-1:0]    rsp_count
);

   logic [DATA_WIDTH-1:0] mem [DEPTH];
   logic [DATA_WIDTH-1:0] rdata_ff;

   dq_op_type             op_ff;
   logic [INDEX_W-1:0]    idx_ff;
   logic [DATA_WIDTH-1:0] din_ff;
   logic [SLOT_W-1:0]     head_ff, head_in;
   logic [COUNT_W-1:0]    count_ff, count_in;
   logic [COUNT_W-1:0]    ptr_ff, ptr_in;

   logic                  rsp_valid_ff;
   logic [DATA_WIDTH-1:0] rsp_data_ff;
   dq_status_type         rsp_status_ff;
   logic [COUNT_W-1:0]    rsp_count_ff;

   dq_status_type         st;
   logic                  full, empty, idx_lt_count, is_insert;
   logic [SLOT_W-1:0]     target_slot, walk_slot, nbr_slot;
   logic [SLOT_W-1:0]     wr_addr, rd_addr;
   logic [DATA_WIDTH-1:0] wr_data;
   logic                  we, re;
   logic [DATA_WIDTH-1:0] data_res;

   function automatic logic [SLOT_W-1:0] slot_of(input logic [SLOT_W-1:0] head,
                                                 input logic [COUNT_W-1:0] pos);
      return head + pos[SLOT_W-1:0];
   endfunction

   assign full         = (count_ff == COUNT_W'(DEPTH));
   assign empty        = (count_ff == '0);
   assign idx_lt_count = (idx_ff < count_ff);
   assign is_insert    = (op_ff == OP_INSERT);

   always_comb begin
      st = ST_OK;
      unique case (op_ff)
         OP_PUSH_BACK, OP_PUSH_FRONT: begin
            if (full) st = ST_FULL;
         end
         OP_POP_BACK, OP_POP_FRONT: begin
            if (empty) st = ST_EMPTY;
         end
         OP_READ, OP_WRITE: begin
            if (!idx_lt_count) st = ST_RANGE;
         end
         OP_INSERT: begin
            priority if (full)               st = ST_FULL;
            else if (idx_ff > count_ff)      st = ST_RANGE;
            else                             st = ST_OK;
         end
         OP_ERASE: begin
            priority if (empty)              st = ST_EMPTY;
            else if (!idx_lt_count)          st = ST_RANGE;
            else                             st = ST_OK;
         end
         default: st = ST_OK;
      endcase
   end

   always_comb begin
      unique case (op_ff)
         OP_PUSH_BACK:  target_slot = slot_of(head_ff, count_ff);
         OP_PUSH_FRONT: target_slot = head_ff - SLOT_W'(1);
         OP_POP_BACK:   target_slot = slot_of(head_ff, count_ff - COUNT_W'(1));
         OP_POP_FRONT:  target_slot = head_ff;
         default:       target_slot = slot_of(head_ff, idx_ff);
      endcase
   end

   // insert walks from the back down, erase from the index up
   assign walk_slot = slot_of(head_ff, ptr_ff);
   assign nbr_slot  = is_insert ? slot_of(head_ff, ptr_ff - COUNT_W'(1))
                                : slot_of(head_ff, ptr_ff + COUNT_W'(1));

   assign we      = cmd.wr_target | cmd.shift_wr;
   assign wr_addr = cmd.shift_wr ? walk_slot : target_slot;
   assign wr_data = cmd.shift_wr ? rdata_ff : din_ff;
   assign re      = cmd.rd_target | cmd.shift_rd;
   assign rd_addr = cmd.shift_rd ? nbr_slot : target_slot;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (re) begin
         rdata_ff <= mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         op_ff  <= dq_op_type'(req_opcode);
         idx_ff <= req_index;
         din_ff <= req_data_in;
      end
   end

   always_comb begin
      ptr_in = ptr_ff;
      if (cmd.ptr_load) begin
         ptr_in = is_insert ? count_ff : idx_ff;
      end else if (cmd.shift_wr) begin
         ptr_in = is_insert ? ptr_ff - COUNT_W'(1) : ptr_ff + COUNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      ptr_ff <= ptr_in;
   end

   always_comb begin
      head_in  = head_ff;
      count_in = count_ff;
      if (cmd.finish && st == ST_OK) begin
         unique case (op_ff)
            OP_PUSH_BACK, OP_INSERT: count_in = count_ff + COUNT_W'(1);
            OP_PUSH_FRONT: begin
               count_in = count_ff + COUNT_W'(1);
               head_in  = head_ff - SLOT_W'(1);
            end
            OP_POP_BACK, OP_ERASE: count_in = count_ff - COUNT_W'(1);
            OP_POP_FRONT: begin
               count_in = count_ff - COUNT_W'(1);
               head_in  = head_ff + SLOT_W'(1);
            end
            default: count_in = count_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         count_ff <= '0;
      end else begin
         head_ff  <= head_in;
         count_ff <= count_in;
      end
   end

   always_comb begin
      data_res = '0;
      if (st == ST_OK && (op_ff == OP_POP_BACK || op_ff == OP_POP_FRONT ||
                          op_ff == OP_READ)) begin
         data_res = rdata_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.finish) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.finish) begin
         rsp_data_ff   <= data_res;
         rsp_status_ff <= st;
         rsp_count_ff  <= count_in;
      end
   end

   assign stat.op         = op_ff;
   assign stat.err        = (st != ST_OK);
   assign stat.shift_more = is_insert ? (ptr_ff > idx_ff)
                                      : ((ptr_ff + COUNT_W'(1)) < count_ff);
   assign stat.out_free   = !rsp_valid_ff || rsp_ready;

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_data_out = rsp_data_ff;
   assign rsp_status   = rsp_status_ff;
   assign rsp_count    = rsp_count_ff;

   `DQ_ASSERT(a_count_bound, count_ff <= COUNT_W'(DEPTH), "element count beyond capacity")
   `DQ_ASSERT(a_rsp_count, cmd.finish |=> rsp_count_ff == count_ff, "response count stale")
   `DQ_ASSERT(a_one_writer, !(cmd.wr_target && cmd.shift_wr), "two storage writes at once")

endmodule

[hw/rtl/dq_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dq_ctrl
// Sequencer: decode, single access, shift walk for insert/erase, insert placement, finish.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"
module dq_ctrl
   import dq_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  dq_stat_type stat,
   output dq_cmd_type  cmd
);

   typedef enum logic [5:0] {
      S_IDLE     = 6'b000001,
      S_DECODE   = 6'b000010,
      S_SHIFT_RD = 6'b000100,
      S_SHIFT_WR = 6'b001000,
      S_PLACE    = 6'b010000,
      S_FINISH   = 6'b100000
   } dq_state_type;

   dq_state_type state_ff, state_in;

   assign req_ready = (state_ff == S_IDLE);

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load_req = 1'b1;
               state_in     = S_DECODE;
            end
         end
         S_DECODE: begin
            if (stat.err) begin
               state_in = S_FINISH;
            end else begin
               unique case (stat.op)
                  OP_PUSH_BACK, OP_PUSH_FRONT, OP_WRITE: begin
                     cmd.wr_target = 1'b1;
                     state_in      = S_FINISH;
                  end
                  OP_POP_BACK, OP_POP_FRONT, OP_READ: begin
                     cmd.rd_target = 1'b1;
                     state_in      = S_FINISH;
                  end
                  default: begin
                     cmd.ptr_load = 1'b1;
                     state_in     = S_SHIFT_RD;
                  end
               endcase
            end
         end
         S_SHIFT_RD: begin
            priority if (stat.shift_more) begin
               cmd.shift_rd = 1'b1;
               state_in     = S_SHIFT_WR;
            end else if (stat.op == OP_INSERT) begin
               state_in = S_PLACE;
            end else begin
               state_in = S_FINISH;
            end
         end
         S_SHIFT_WR: begin
            cmd.shift_wr = 1'b1;
            state_in     = S_SHIFT_RD;
         end
         S_PLACE: begin
            cmd.wr_target = 1'b1;
            state_in      = S_FINISH;
         end
         S_FINISH: begin
            if (stat.out_free) begin
               cmd.finish = 1'b1;
               state_in   = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   `DQ_ASSERT(a_finish_free, cmd.finish |-> stat.out_free, "response overwritten")
   `DQ_ASSERT(a_wr_after_rd, cmd.shift_wr |-> $past(cmd.shift_rd), "shift write without read")
   `DQ_ASSERT(a_walk_ok, cmd.ptr_load |-> !stat.err, "shift walk on a failed request")

endmodule

[hw/rtl/double_ended_queue.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// double_ended_queue
// Fixed-capacity double-ended queue of 64 x 32-bit elements in a ring buffer.
// ----------------------------------------------------------------------------
// One request in, one response out. Every request carries an opcode (push
// back/front, pop back/front, read, write, insert and erase at an index from
// the front) and yields one response with the read or popped data (zero
// otherwise), a status (ok, full, empty, index out of range) and the element
// count after the operation. A failed request changes nothing. Requests are
// handled one at a time by a sequencer over a single-write, single-read
// storage array with registered read data. Insert and erase move elements
// one at a time, each with one storage read followed by one storage write.
// A finished response sits in an output register, so the next request is
// accepted while it waits to be taken; the sequencer holds its final step
// only if the previous response is still there.
// ----------------------------------------------------------------------------
module double_ended_queue
   import dq_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   // request: opcode [2:0], index [9:3], data_in [41:10], zero pad [47:42]
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [47:0] req_tdata,
   // response: data_out [31:0], status [33:32], count [40:34], zero pad [47:41]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [47:0] rsp_tdata
);

   dq_cmd_type            cmd;
   dq_stat_type           stat;
   logic [DATA_WIDTH-1:0] rsp_data_out;
   logic [STATUS_W-1:0]   rsp_status;
   logic [COUNT_W-1:0]    rsp_count;

   // sequence each request through decode, access, walk and finish
   dq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_tvalid),
      .req_ready (req_tready),
      .stat      (stat),
      .cmd       (cmd)
   );

   // hold storage, head/count and the response register
   dq_datapath u_datapath (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .stat         (stat),
      .req_opcode   (req_tdata[2:0]),
      .req_index    (req_tdata[9:3]),
      .req_data_in  (req_tdata[41:10]),
      .rsp_valid    (rsp_tvalid),
      .rsp_ready    (rsp_tready),
      .rsp_data_out (rsp_data_out),
      .rsp_status   (rsp_status),
      .rsp_count    (rsp_count)
   );

   // pack the response, pad to whole bytes
   assign rsp_tdata = {7'b0, rsp_count, rsp_status, rsp_data_out};

endmodule

[bench/tb_double_ended_queue.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_double_ended_queue
// Self-checking bench for the ring-buffer double-ended queue.
// ----------------------------------------------------------------------------
// A mirror class holds the queue contents as an SV queue. It works out the
// response of every accepted request (data, status, count), and then compares
// each response against the oldest response still owed. A short directed
// pass hits the empty, out-of-range and append corners. Random traffic then
// swings between fill, drain and mixed phases, so the queue runs full and
// empty many times over. Both sides idle in random bursts, except in the
// final stretch.
// ----------------------------------------------------------------------------
module tb_double_ended_queue;
   import dq_pkg::*;

   localparam int CLOCK_HALF      = 5;
   localparam int RANDOM_REQUESTS = 900;
   localparam int CALM_TAIL       = 120;   // last requests sent with no idling
   localparam int DRAIN_EVERY     = 200;   // sender pauses until all answered
   localparam int SETTLE_CYCLES   = 150;   // longer than a full-depth shift
   localparam int CYCLE_LIMIT     = 1000000;

   typedef enum int {MOOD_FILL, MOOD_DRAIN, MOOD_MIXED} traffic_mood_type;

   typedef struct packed {
      logic [DATA_WIDTH-1:0] data;
      dq_status_type         status;
      logic [COUNT_W-1:0]    count;
   } dq_result_type;

   // Mirror of the queue: element 0 is the front.
   class deque_mirror;
      logic [DATA_WIDTH-1:0] elements[$];
      dq_result_type         results_due[$];
      int                    errors;
      int                    checked;
      int                    peak_level;
      int                    status_tally[4];

      function int level();
         return elements.size();
      endfunction

      function int pending();
         return results_due.size();
      endfunction

      // Apply one accepted request and queue the response it must produce.
      function void note_request(dq_op_type op, logic [INDEX_W-1:0] idx,
                                 logic [DATA_WIDTH-1:0] din);
         dq_result_type r;
         r.data   = '0;
         r.status = ST_OK;
         case (op)
            OP_PUSH_BACK: begin
               if (elements.size() >= DEPTH) r.status = ST_FULL;
               else elements.insert(elements.size(), din);
            end
            OP_PUSH_FRONT: begin
               if (elements.size() >= DEPTH) r.status = ST_FULL;
               else elements.insert(0, din);
            end
            OP_POP_BACK: begin
               if (elements.size() == 0) r.status = ST_EMPTY;
               else begin
                  r.data = elements[elements.size() - 1];
                  elements.delete(elements.size() - 1);
               end
            end
            OP_POP_FRONT: begin
               if (elements.size() == 0) r.status = ST_EMPTY;
               else begin
                  r.data = elements[0];
                  elements.delete(0);
               end
            end
            OP_READ: begin
               if (idx >= elements.size()) r.status = ST_RANGE;
               else r.data = elements[idx];
            end
            OP_WRITE: begin
               if (idx >= elements.size()) r.status = ST_RANGE;
               else elements[idx] = din;
            end
            OP_INSERT: begin
               // full is reported ahead of a bad index
               if (elements.size() >= DEPTH) r.status = ST_FULL;
               else if (idx > elements.size()) r.status = ST_RANGE;
               else elements.insert(idx, din);
            end
            default: begin
               if (elements.size() == 0) r.status = ST_EMPTY;
               else if (idx >= elements.size()) r.status = ST_RANGE;
               else elements.delete(idx);
            end
         endcase
         r.count = COUNT_W'(elements.size());
         if (elements.size() > peak_level) peak_level = elements.size();
         status_tally[r.status]++;
         results_due.insert(results_due.size(), r);
      endfunction

      // Compare one accepted response with the oldest response owed.
      function void check_response(logic [47:0] tdata);
         dq_result_type exp;
         logic [DATA_WIDTH-1:0] got_data;
         logic [STATUS_W-1:0]   got_status;
         logic [COUNT_W-1:0]    got_count;
         got_data   = tdata[31:0];
         got_status = tdata[33:32];
         got_count  = tdata[40:34];
         if (results_due.size() == 0) begin
            $display("%0t: response %h with no request outstanding", $time, tdata);
            errors++;
            return;
         end
         exp = results_due[0];
         results_due.delete(0);
         checked++;
         if (got_data !== exp.data) begin
            $display("%0t: data_out mismatch, expected %h, got %h",
                     $time, exp.data, got_data);
            errors++;
         end
         if (got_status !== exp.status) begin
            $display("%0t: status mismatch, expected %0d, got %0d",
                     $time, exp.status, got_status);
            errors++;
         end
         if (got_count !== exp.count) begin
            $display("%0t: count mismatch, expected %0d, got %0d",
                     $time, exp.count, got_count);
            errors++;
         end
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [47:0] req_tdata;    // opcode [2:0], index [9:3], data_in [41:10], pad
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [47:0] rsp_tdata;    // data_out [31:0], status [33:32], count [40:34], pad

   deque_mirror mirror = new();
   bit          quiet = 1'b0;    // set for the calm final stretch
   int          cycle_count = 0;
   int          stall_left = 0;
   int          requests_sent = 0;

   double_ended_queue dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always begin
      #CLOCK_HALF clock = 1'b1;
      #CLOCK_HALF clock = 1'b0;
   end

   // Abort a hung run.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d responses still owed",
                  cycle_count, mirror.pending());
         $display("tb_double_ended_queue: done, errors");
         $finish;
      end
   end

   // Response side: stall in random bursts, never starting one when quiet.
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (stall_left != 0) begin
         stall_left <= stall_left - 1;
         rsp_tready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
         stall_left <= $urandom_range(1, 18) - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // Sample the response handshake mid-cycle: both sides are stable until the
   // next rising edge, so this sees exactly what that edge accepts.
   always @(negedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) mirror.check_response(rsp_tdata);
   end

   // Present one request, hold it until accepted, then record it.
   task automatic send_request(input dq_op_type op, input logic [INDEX_W-1:0] idx,
                               input logic [DATA_WIDTH-1:0] din);
      logic took;
      if (!quiet && $urandom_range(0, 7) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 18)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {6'b0, din, idx, op};
      do begin
         @(negedge clock);
         took = req_tready;
         @(posedge clock);
      end while (!took);
      mirror.note_request(op, idx, din);
      requests_sent++;
   endtask

   // Hold off the sender until every owed response has come back.
   task automatic wait_for_drain();
      req_tvalid <= 1'b0;
      while (mirror.pending() != 0) @(posedge clock);
   endtask

   // Favor growth or shrinkage by mood; a slice of every mood is any opcode.
   function automatic dq_op_type pick_op(traffic_mood_type mood);
      int roll;
      roll = $urandom_range(0, 99);
      if (mood == MOOD_FILL && roll < 85) begin
         if (roll < 40) return OP_PUSH_BACK;
         if (roll < 65) return OP_PUSH_FRONT;
         return OP_INSERT;
      end
      if (mood == MOOD_DRAIN && roll < 85) begin
         if (roll < 35) return OP_POP_BACK;
         if (roll < 65) return OP_POP_FRONT;
         return OP_ERASE;
      end
      return dq_op_type'($urandom_range(0, 7));
   endfunction

   // Mostly a valid position for the current level, sometimes any 7-bit index.
   function automatic logic [INDEX_W-1:0] pick_index(dq_op_type op, int lvl);
      if ($urandom_range(0, 99) < 80) begin
         if (op == OP_INSERT) return INDEX_W'($urandom_range(0, lvl));
         if (lvl > 0) return INDEX_W'($urandom_range(0, lvl - 1));
      end
      return INDEX_W'($urandom_range(0, (1 << INDEX_W) - 1));
   endfunction

   initial begin
      traffic_mood_type mood;
      int               seg_left;
      dq_op_type        op;

      reset      <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata  <= '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: every failure on an empty queue first.
      send_request(OP_POP_BACK,   7'd0,   32'h0);
      send_request(OP_POP_FRONT,  7'd0,   32'h0);
      send_request(OP_ERASE,      7'd0,   32'h0);
      send_request(OP_READ,       7'd0,   32'h0);
      send_request(OP_WRITE,      7'd0,   32'hFFFF_FFFF);
      send_request(OP_INSERT,     7'd1,   32'h1234_5678);
      // Build a few elements through every entry path, append via insert.
      send_request(OP_INSERT,     7'd0,   32'hFFFF_FFFF);
      send_request(OP_PUSH_BACK,  7'd0,   32'h0000_0000);
      send_request(OP_PUSH_FRONT, 7'd0,   32'hA5A5_A5A5);
      send_request(OP_INSERT,     7'd3,   32'h8000_0001);
      send_request(OP_INSERT,     7'd1,   32'h0F0F_0F0F);
      // Reads at both ends, just past the end and at the top index.
      send_request(OP_READ,       7'd0,   32'h0);
      send_request(OP_READ,       7'd4,   32'h0);
      send_request(OP_READ,       7'd5,   32'h0);
      send_request(OP_READ,       7'h7F,  32'h0);
      send_request(OP_WRITE,      7'd2,   32'h5A5A_5A5A);
      send_request(OP_WRITE,      7'h7F,  32'hDEAD_BEEF);
      send_request(OP_READ,       7'd2,   32'h0);
      // Erase at the front, the back, beyond the end and in the middle.
      send_request(OP_ERASE,      7'd0,   32'h0);
      send_request(OP_ERASE,      7'd3,   32'h0);
      send_request(OP_ERASE,      7'h7F,  32'h0);
      send_request(OP_ERASE,      7'd1,   32'h0);
      send_request(OP_POP_BACK,   7'd0,   32'h0);
      send_request(OP_POP_FRONT,  7'd0,   32'h0);
      wait_for_drain();

      // Random: swing between fill and drain phases with mixed spells between,
      // so full and empty are both reached repeatedly.
      mood     = MOOD_FILL;
      seg_left = $urandom_range(100, 160);
      for (int n = 0; n < RANDOM_REQUESTS; n++) begin
         if (n == RANDOM_REQUESTS - CALM_TAIL) quiet = 1'b1;
         if (!quiet && n % DRAIN_EVERY == DRAIN_EVERY - 1) wait_for_drain();
         if (seg_left == 0) begin
            if (mood != MOOD_MIXED) begin
               mood     = MOOD_MIXED;
               seg_left = $urandom_range(30, 80);
            end else begin
               mood     = (mirror.level() >= DEPTH / 2) ? MOOD_DRAIN : MOOD_FILL;
               seg_left = $urandom_range(100, 160);
            end
         end
         seg_left--;
         op = pick_op(mood);
         send_request(op, pick_index(op, mirror.level()), $urandom);
      end

      // Let the last responses arrive, then watch for strays.
      wait_for_drain();
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("%0d requests sent, %0d responses checked, peak level %0d of %0d",
               requests_sent, mirror.checked, mirror.peak_level, DEPTH);
      $display("status mix: ok %0d, full %0d, empty %0d, out of range %0d",
               mirror.status_tally[ST_OK], mirror.status_tally[ST_FULL],
               mirror.status_tally[ST_EMPTY], mirror.status_tally[ST_RANGE]);
      if (mirror.errors == 0 && mirror.pending() == 0) begin
         $display("tb_double_ended_queue: done, clean");
      end else begin
         $display("tb_double_ended_queue: done, errors");
      end
      $finish;
   end

endmodule

[double_ended_queue.f]
+incdir+hw/rtl
hw/rtl/dq_pkg.sv
hw/rtl/dq_datapath.sv
hw/rtl/dq_ctrl.sv
hw/rtl/double_ended_queue.sv
bench/tb_double_ended_queue.sv
